### rtl/core/rrbm_pkg.sv
// ----------------------------------------------------------------------------
// ROM/RAM bank mapper package
// Shared constants, region codes and the result item type of the mapper.
// ----------------------------------------------------------------------------
package rrbm_pkg;

    localparam int RamDepthDef    = 32768;
    localparam int RomAddrBitsDef = 21;
    localparam int QueueDepth     = 4;

    localparam int RamSizeW = 16;
    localparam int RomAddrW = 21;
    localparam int CfgDataW = 21;
    localparam int CfgIdxW  = 1;

    localparam logic CmdRead  = 1'b0;
    localparam logic CmdWrite = 1'b1;

    localparam logic [CfgIdxW-1:0] CfgRamSize = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgRomMask = 1'b1;

    localparam logic [2:0] RgnRamEnable = 3'd0;
    localparam logic [2:0] RgnLowBank   = 3'd1;
    localparam logic [2:0] RgnHighBank  = 3'd2;
    localparam logic [2:0] RgnMode      = 3'd3;
    localparam logic [2:0] RgnCartRam   = 3'd5;

    localparam logic [3:0] RamEnableKey = 4'hA;
    localparam logic [7:0] RamOpenData  = 8'hFF;

    localparam logic [RomAddrW-1:0] RomMaskReset = 21'h007FFF;

    typedef struct packed {
        logic [7:0]          read_data;
        logic                rom_read;
        logic [RomAddrW-1:0] rom_address;
        logic                bad_address;
    } t_res;

endpackage

### rtl/core/rrbm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module rrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rrbm_front.sv
// ----------------------------------------------------------------------------
// Bank mapper front end
// Accepts bus accesses, decodes the region, updates the bank registers,
// drives the cartridge RAM and forms the result in the following cycle.
// ----------------------------------------------------------------------------
module rrbm_front #(
    parameter int RAM_DEPTH     = 32768,
    parameter int ROM_ADDR_BITS = 21
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_acc,
    input  logic                           i_cmd,
    input  logic [15:0]                    i_bus_address,
    input  logic [7:0]                     i_write_data,
    input  logic                           i_cfg_we,
    input  logic [rrbm_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [rrbm_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic                           o_push,
    output rrbm_pkg::t_res                 o_res
);

    import rrbm_pkg::*;

    localparam int RamAw = $clog2(RAM_DEPTH);
    localparam logic [RamSizeW:0] RamDepthLim = (RamSizeW+1)'(RAM_DEPTH);
    localparam logic [RomAddrW-1:0] RomBitsMask =
        RomAddrW'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    logic [RamSizeW-1:0] r_cart_bytes;
    logic [RomAddrW-1:0] r_rom_mask;
    logic                r_ram_enable;
    logic [4:0]          r_low_bank;
    logic [1:0]          r_high_bank;
    logic                r_ram_mode;

    logic                r_s1_valid;
    logic                r_s1_ram_rd;
    logic                r_s1_hit;
    t_res                r_s1_res;

    logic [2:0]          region;
    logic [14:0]         ram_banked;
    logic [14:0]         ram_plain;
    logic                ok_banked;
    logic                ok_plain;
    logic                hit_banked;
    logic                ram_hit;
    logic [14:0]         ram_where;
    logic [RomAddrW-1:0] rom_phys;
    logic                is_write;
    logic                is_ram_rgn;
    logic                ram_en;
    logic                ram_we;
    logic [7:0]          ram_q;
    logic [4:0]          wr_bank;
    t_res                n_s1_res;

    assign region     = i_bus_address[15:13];
    assign is_write   = (i_cmd == CmdWrite);
    assign is_ram_rgn = (region == RgnCartRam);

    assign ram_banked = {r_high_bank, i_bus_address[12:0]};
    assign ram_plain  = {2'b00, i_bus_address[12:0]};
    assign ok_banked  = r_ram_enable && ({2'b00, ram_banked} < {1'b0, r_cart_bytes})
                        && ({2'b00, ram_banked} < RamDepthLim);
    assign ok_plain   = r_ram_enable && ({2'b00, ram_plain} < {1'b0, r_cart_bytes})
                        && ({2'b00, ram_plain} < RamDepthLim);
    assign hit_banked = r_ram_mode && ok_banked;
    assign ram_hit    = hit_banked || ok_plain;
    assign ram_where  = hit_banked ? ram_banked : ram_plain;

    always_comb begin
        if (!i_bus_address[14]) begin
            rom_phys = r_ram_mode ? {r_high_bank, 5'd0, i_bus_address[13:0]}
                                  : {7'd0, i_bus_address[13:0]};
        end else begin
            rom_phys = {r_high_bank, r_low_bank, i_bus_address[13:0]};
        end
        rom_phys = rom_phys & r_rom_mask & RomBitsMask;
    end

    always_comb begin
        n_s1_res = '0;
        if (!is_write) begin
            if (!i_bus_address[15]) begin
                n_s1_res.rom_read    = 1'b1;
                n_s1_res.rom_address = rom_phys;
            end else if (!is_ram_rgn) begin
                n_s1_res.bad_address = 1'b1;
            end
        end
    end

    assign ram_en  = i_acc && is_ram_rgn && ram_hit;
    assign ram_we  = is_write;
    assign wr_bank = i_write_data[4:0];

    rrbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_cart_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_where[RamAw-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_bytes <= '0;
            r_rom_mask   <= RomMaskReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgRamSize: r_cart_bytes <= i_cfg_data[RamSizeW-1:0];
                CfgRomMask: r_rom_mask   <= i_cfg_data[RomAddrW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enable <= 1'b0;
            r_low_bank   <= 5'd1;
            r_high_bank  <= 2'd0;
            r_ram_mode   <= 1'b0;
        end else if (i_acc && is_write) begin
            case (region)
                RgnRamEnable: r_ram_enable <= (i_write_data[3:0] == RamEnableKey);
                RgnLowBank:   r_low_bank   <= (wr_bank == 5'd0) ? 5'd1 : wr_bank;
                RgnHighBank:  r_high_bank  <= i_write_data[1:0];
                RgnMode:      r_ram_mode   <= i_write_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_ram_rd <= !is_write && is_ram_rgn;
            r_s1_hit    <= ram_hit;
            r_s1_res    <= n_s1_res;
        end
    end

    always_comb begin
        o_res = r_s1_res;
        if (r_s1_ram_rd) begin
            o_res.read_data = r_s1_hit ? ram_q : RamOpenData;
        end
    end

    assign o_push = r_s1_valid;

    a_low_bank_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_bank != 5'd0)
        else $error("low bank register holds zero");

    a_one_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $countones({r_s1_res.rom_read, r_s1_res.bad_address,
                                   r_s1_ram_rd}) <= 1)
        else $error("result item classified as more than one kind");

endmodule

### rtl/core/rrbm_queue.sv
// ----------------------------------------------------------------------------
// Bank mapper result queue
// Holds finished result items until the consumer takes them, and reports
// whether another item may enter the front end.
// ----------------------------------------------------------------------------
module rrbm_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rrbm_pkg::t_res i_res,
    input  logic           i_inflight,
    input  logic           i_stall,
    output logic           o_room,
    output logic           o_valid,
    output rrbm_pkg::t_res o_res
);

    import rrbm_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LvlW = $clog2(DEPTH + 1);
    localparam logic [LvlW:0] DepthLim = (LvlW+1)'(DEPTH);

    t_res            r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [LvlW-1:0] r_level;
    logic [PtrW-1:0] n_wptr;
    logic [PtrW-1:0] n_rptr;
    logic            pop;

    assign o_valid = (r_level != '0);
    assign o_res   = r_mem[r_rptr];
    assign pop     = o_valid && !i_stall;
    assign o_room  = ({1'b0, r_level} + (LvlW+1)'(i_inflight)) < DepthLim;

    assign n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ({1'b0, r_level} < DepthLim) || pop)
        else $error("result item pushed into a full queue");

    a_level_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_level} <= DepthLim)
        else $error("queue level beyond its depth");

    a_room_means_space : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_room |=> ({1'b0, r_level} < DepthLim) || !i_push || pop)
        else $error("item admitted without space in the queue");

endmodule

### rtl/core/rom_ram_bank_mapper_two_mode_unit.sv
// Each result item is registered in the front end, then in the queue, before output.
// One access per cycle while o_stall is low; a four-entry queue absorbs output stalls.
// The cartridge RAM is single-port, used once per accepted RAM access that hits.
// Reset (synchronous, active low) restores the bank registers and configuration
// and empties the queue; cartridge RAM contents are left as they are.
// ----------------------------------------------------------------------------
// ROM/RAM bank mapper, two-mode
// Top level of the cartridge bank controller: front end with bank registers
// and cartridge RAM, followed by the result queue.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_two_mode_unit #(
    parameter int RAM_DEPTH     = rrbm_pkg::RamDepthDef,
    parameter int ROM_ADDR_BITS = rrbm_pkg::RomAddrBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [15:0]                    i_bus_address,
    input  logic [7:0]                     i_write_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_read_data,
    output logic                           o_rom_read,
    output logic [rrbm_pkg::RomAddrW-1:0]  o_rom_address,
    output logic                           o_bad_address,
    input  logic                           i_cfg_we,
    input  logic [rrbm_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [rrbm_pkg::CfgDataW-1:0]  i_cfg_data
);

    import rrbm_pkg::*;

    logic acc;
    logic push;
    logic room;
    t_res front_res;
    t_res out_res;

    assign o_stall = !room;
    assign acc     = i_valid && room;

    rrbm_front #(
        .RAM_DEPTH     (RAM_DEPTH),
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_cmd         (i_cmd),
        .i_bus_address (i_bus_address),
        .i_write_data  (i_write_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_res         (front_res)
    );

    rrbm_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (front_res),
        .i_inflight (push),
        .i_stall    (i_stall),
        .o_room     (room),
        .o_valid    (o_valid),
        .o_res      (out_res)
    );

    assign o_read_data   = out_res.read_data;
    assign o_rom_read    = out_res.rom_read;
    assign o_rom_address = out_res.rom_address;
    assign o_bad_address = out_res.bad_address;

endmodule
